### rtl/byte_string_hash_unit_macros.svh
// Assertion macros shared by the byte string hash checker
`ifndef BYTE_STRING_HASH_UNIT_MACROS_SVH
`define BYTE_STRING_HASH_UNIT_MACROS_SVH

// Clocked check, disabled while reset is high
`define BSH_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds across reset
`define BSH_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/bsh_pkg.sv
// Package with types and constants for the byte string hash unit
`timescale 1ns / 1ps

package bsh_pkg;

   localparam int LENGTH_BITS_DEFAULT = 24;
   localparam int LEN_PORT_BITS       = 24;
   localparam int HASH_BITS           = 32;

   localparam logic ACTION_START = 1'b0;
   localparam logic ACTION_WORD  = 1'b1;

   // Four-byte mixing round
   localparam logic [31:0] K_ROUND_MS    = 32'd509;
   localparam logic [31:0] K_ROUND_S0    = 32'd307;
   localparam logic [31:0] K_ROUND_S1    = 32'd1319;
   localparam logic [31:0] K_ROUND_LEN   = 32'd17;
   localparam logic [31:0] K_ROUND_LADD  = 32'd5;
   localparam logic [31:0] K_ROUND_MS2   = 32'd5309;
   localparam logic [31:0] K_ROUND_S2    = 32'd3313;
   localparam logic [31:0] K_ROUND_S3    = 32'd9337;
   localparam logic [31:0] K_ROUND_SADD  = 32'd517;

   // Tail chain
   localparam logic [31:0] K_TAIL0_MF    = 32'd7703;
   localparam logic [31:0] K_TAIL0_S     = 32'd503;
   localparam logic [31:0] K_TAIL1_MS    = 32'd7717;
   localparam logic [31:0] K_TAIL1_S     = 32'd509;
   localparam logic [31:0] K_TAIL2_MF    = 32'd9323;
   localparam logic [31:0] K_TAIL2_ADD   = 32'd11;
   localparam logic [31:0] K_TAIL2_S     = 32'd523;
   localparam logic [31:0] K_TAIL3_MS    = 32'd7727;
   localparam logic [31:0] K_TAIL3_ADD   = 32'd127;
   localparam logic [31:0] K_TAIL3_SADD  = 32'd313;
   localparam logic [31:0] K_TAIL3_S     = 32'd547;

   // Finish
   localparam logic [31:0] K_FIN_MF      = 32'd29311;
   localparam logic [31:0] K_FIN_MF_ADD  = 32'd59;
   localparam logic [31:0] K_FIN_MS      = 32'd7321;
   localparam logic [31:0] K_FIN_MS_ADD  = 32'd120501;
   localparam logic [31:0] K_FIN_LEN_MSK = 32'h00ff_ffff;
   localparam logic [31:0] K_FIN_LEN_ADD = 32'd11;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_CAPTURE,
      CMD_ROUND,
      CMD_TAIL0,
      CMD_TAIL1,
      CMD_TAIL2,
      CMD_TAIL3,
      CMD_FIN_MUL,
      CMD_FIN_OUT
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_TAIL0,
      ST_TAIL1,
      ST_TAIL2,
      ST_TAIL3,
      ST_FIN_MUL,
      ST_FIN_OUT
   } state_type;

   typedef struct packed {
      logic active;
      logic len_zero;
      logic rem_gt1;
      logic rem_gt2;
      logic rem_gt3;
      logic rem_gt4;
      logic out_free;
   } status_type;

   function automatic logic [31:0] sext8(input logic [7:0] b);
      sext8 = {{24{b[7]}}, b};
   endfunction

endpackage

### rtl/bsh_datapath.sv
// Datapath of the byte string hash unit: hash state, mixing steps and result register
`timescale 1ns / 1ps

module bsh_datapath #(
   parameter int LENGTH_BITS = bsh_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bsh_pkg::cmd_type                  cmd,
   output bsh_pkg::status_type               status,
   input  logic [bsh_pkg::LEN_PORT_BITS-1:0] req_string_length,
   input  logic [7:0]                        req_byte_a,
   input  logic [7:0]                        req_byte_b,
   input  logic [7:0]                        req_byte_c,
   input  logic [7:0]                        req_byte_d,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bsh_pkg::HASH_BITS-1:0]     rsp_hash_value
);

   localparam int WIDE_BITS = (LENGTH_BITS > bsh_pkg::LEN_PORT_BITS) ?
                              LENGTH_BITS : bsh_pkg::LEN_PORT_BITS;
   localparam logic [LENGTH_BITS-1:0] REM_ONE   = LENGTH_BITS'(1);
   localparam logic [LENGTH_BITS-1:0] REM_TWO   = LENGTH_BITS'(2);
   localparam logic [LENGTH_BITS-1:0] REM_THREE = LENGTH_BITS'(3);
   localparam logic [LENGTH_BITS-1:0] REM_WORD  = LENGTH_BITS'(4);

   logic [31:0]            mix_first_ff,  mix_first_in;
   logic [31:0]            mix_second_ff, mix_second_in;
   logic [LENGTH_BITS-1:0] remaining_ff,  remaining_in;
   logic [LENGTH_BITS-1:0] total_ff,      total_in;
   logic                   active_ff,     active_in;
   logic [7:0]             byte_ff [4];
   logic [7:0]             byte_in [4];
   logic [31:0]            prod_first_ff,  prod_first_in;
   logic [31:0]            prod_second_ff, prod_second_in;
   logic [31:0]            hash_ff,        hash_in;
   logic                   rsp_valid_ff,   rsp_valid_in;

   logic [WIDE_BITS-1:0]   len_wide;
   logic [LENGTH_BITS-1:0] len_value;
   logic [31:0]            s0, s1, s2, s3;
   logic [31:0]            fin_mix;
   logic [31:0]            fin_fallback;
   logic                   out_free;

   assign len_wide  = WIDE_BITS'(req_string_length);
   assign len_value = len_wide[LENGTH_BITS-1:0];

   assign s0 = bsh_pkg::sext8(byte_ff[0]);
   assign s1 = bsh_pkg::sext8(byte_ff[1]);
   assign s2 = bsh_pkg::sext8(byte_ff[2]);
   assign s3 = bsh_pkg::sext8(byte_ff[3]);

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Fall back to mix_first, then mix_second, then masked length plus 11 when the mix is zero
   assign fin_mix = (prod_first_ff + bsh_pkg::K_FIN_MF_ADD) ^
                    (prod_second_ff + bsh_pkg::K_FIN_MS_ADD);
   assign fin_fallback = (mix_first_ff != '0) ? mix_first_ff :
                         (mix_second_ff != '0) ? mix_second_ff :
                         ((32'(total_ff) & bsh_pkg::K_FIN_LEN_MSK) + bsh_pkg::K_FIN_LEN_ADD);

   always_comb begin
      mix_first_in   = mix_first_ff;
      mix_second_in  = mix_second_ff;
      remaining_in   = remaining_ff;
      total_in       = total_ff;
      active_in      = active_ff;
      byte_in        = byte_ff;
      prod_first_in  = prod_first_ff;
      prod_second_in = prod_second_ff;
      hash_in        = hash_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      case (cmd)
         bsh_pkg::CMD_LOAD: begin
            mix_first_in  = '0;
            mix_second_in = 32'(len_value);
            remaining_in  = len_value;
            total_in      = len_value;
            active_in     = (len_value != '0);
         end
         bsh_pkg::CMD_CAPTURE: begin
            byte_in[0] = req_byte_a;
            byte_in[1] = req_byte_b;
            byte_in[2] = req_byte_c;
            byte_in[3] = req_byte_d;
         end
         bsh_pkg::CMD_ROUND: begin
            mix_first_in  = (mix_second_ff * bsh_pkg::K_ROUND_MS + s0 * bsh_pkg::K_ROUND_S0) ^
                            (s1 * bsh_pkg::K_ROUND_S1);
            mix_second_in = (32'(remaining_ff) * bsh_pkg::K_ROUND_LEN + bsh_pkg::K_ROUND_LADD +
                             mix_second_ff * bsh_pkg::K_ROUND_MS2) ^
                            (s2 * bsh_pkg::K_ROUND_S2 + s3 * bsh_pkg::K_ROUND_S3 +
                             bsh_pkg::K_ROUND_SADD);
            remaining_in  = remaining_ff - REM_WORD;
         end
         bsh_pkg::CMD_TAIL0: begin
            mix_first_in = (mix_first_ff * bsh_pkg::K_TAIL0_MF) ^ (s0 * bsh_pkg::K_TAIL0_S);
            active_in    = 1'b0;
         end
         bsh_pkg::CMD_TAIL1: begin
            mix_second_in = (mix_second_ff * bsh_pkg::K_TAIL1_MS) ^ (s1 * bsh_pkg::K_TAIL1_S);
         end
         bsh_pkg::CMD_TAIL2: begin
            mix_first_in = (mix_first_ff * bsh_pkg::K_TAIL2_MF) ^
                           (bsh_pkg::K_TAIL2_ADD + s2 * bsh_pkg::K_TAIL2_S);
         end
         bsh_pkg::CMD_TAIL3: begin
            mix_second_in = (mix_second_ff * bsh_pkg::K_TAIL3_MS + bsh_pkg::K_TAIL3_ADD) ^
                            (bsh_pkg::K_TAIL3_SADD + s3 * bsh_pkg::K_TAIL3_S);
         end
         bsh_pkg::CMD_FIN_MUL: begin
            prod_first_in  = mix_first_ff * bsh_pkg::K_FIN_MF;
            prod_second_in = mix_second_ff * bsh_pkg::K_FIN_MS;
            remaining_in   = '0;
         end
         bsh_pkg::CMD_FIN_OUT: begin
            hash_in      = (fin_mix != '0) ? fin_mix : fin_fallback;
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mix_first_ff   <= mix_first_in;
      mix_second_ff  <= mix_second_in;
      remaining_ff   <= remaining_in;
      total_ff       <= total_in;
      byte_ff        <= byte_in;
      prod_first_ff  <= prod_first_in;
      prod_second_ff <= prod_second_in;
      hash_ff        <= hash_in;
   end

   always_comb begin
      status.active   = active_ff;
      status.len_zero = (len_value == '0);
      status.rem_gt1  = (remaining_ff > REM_ONE);
      status.rem_gt2  = (remaining_ff > REM_TWO);
      status.rem_gt3  = (remaining_ff > REM_THREE);
      status.rem_gt4  = (remaining_ff > REM_WORD);
      status.out_free = out_free;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = hash_ff;

endmodule

### rtl/bsh_ctrl.sv
// Controller of the byte string hash unit: sequences load, round, tail and finish steps
`timescale 1ns / 1ps

module bsh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_action,
   input  bsh_pkg::status_type status,
   output bsh_pkg::cmd_type    cmd
);

   bsh_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsh_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = bsh_pkg::CMD_NONE;
      req_ready = (state_ff == bsh_pkg::ST_IDLE);
      case (state_ff)
         bsh_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_action == bsh_pkg::ACTION_START) begin
                  cmd      = bsh_pkg::CMD_LOAD;
                  state_in = status.len_zero ? bsh_pkg::ST_FIN_MUL : bsh_pkg::ST_IDLE;
               end else if (status.active) begin
                  cmd      = bsh_pkg::CMD_CAPTURE;
                  state_in = status.rem_gt4 ? bsh_pkg::ST_ROUND : bsh_pkg::ST_TAIL0;
               end
               // drop a word that arrives with no string open
            end
         end
         bsh_pkg::ST_ROUND: begin
            cmd      = bsh_pkg::CMD_ROUND;
            state_in = bsh_pkg::ST_IDLE;
         end
         bsh_pkg::ST_TAIL0: begin
            cmd      = bsh_pkg::CMD_TAIL0;
            state_in = status.rem_gt1 ? bsh_pkg::ST_TAIL1 : bsh_pkg::ST_FIN_MUL;
         end
         bsh_pkg::ST_TAIL1: begin
            cmd      = bsh_pkg::CMD_TAIL1;
            state_in = status.rem_gt2 ? bsh_pkg::ST_TAIL2 : bsh_pkg::ST_FIN_MUL;
         end
         bsh_pkg::ST_TAIL2: begin
            cmd      = bsh_pkg::CMD_TAIL2;
            state_in = status.rem_gt3 ? bsh_pkg::ST_TAIL3 : bsh_pkg::ST_FIN_MUL;
         end
         bsh_pkg::ST_TAIL3: begin
            cmd      = bsh_pkg::CMD_TAIL3;
            state_in = bsh_pkg::ST_FIN_MUL;
         end
         bsh_pkg::ST_FIN_MUL: begin
            cmd      = bsh_pkg::CMD_FIN_MUL;
            state_in = bsh_pkg::ST_FIN_OUT;
         end
         bsh_pkg::ST_FIN_OUT: begin
            // hold until the result register is free
            if (status.out_free) begin
               cmd      = bsh_pkg::CMD_FIN_OUT;
               state_in = bsh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bsh_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/byte_string_hash_unit.sv
// A start word loads the length; a zero-length start then runs the finish steps for its hash.
// A mid-string data word is accepted in idle and then runs the mixing round.
// The last data word runs 1 to 4 tail steps, then the finish steps FIN_MUL and FIN_OUT.
// A new word in a string waits until the single shared round step is done.
// A finished hash waits in an output register while the next word is taken.
// Reset (synchronous, active high) returns the controller to idle and drops any pending hash.
`timescale 1ns / 1ps

module byte_string_hash_unit #(
   parameter int LENGTH_BITS = bsh_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_action,
   input  logic [bsh_pkg::LEN_PORT_BITS-1:0] req_string_length,
   input  logic [7:0]                        req_byte_a,
   input  logic [7:0]                        req_byte_b,
   input  logic [7:0]                        req_byte_c,
   input  logic [7:0]                        req_byte_d,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bsh_pkg::HASH_BITS-1:0]     rsp_hash_value
);

   bsh_pkg::cmd_type    cmd;
   bsh_pkg::status_type status;

   bsh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .status     (status),
      .cmd        (cmd)
   );

   bsh_datapath #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_string_length (req_string_length),
      .req_byte_a        (req_byte_a),
      .req_byte_b        (req_byte_b),
      .req_byte_c        (req_byte_c),
      .req_byte_d        (req_byte_d),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hash_value    (rsp_hash_value)
   );

endmodule

### rtl/bsh_checker.sv
// Port-level checker for the byte string hash unit, bound to the top level
`timescale 1ns / 1ps
`include "byte_string_hash_unit_macros.svh"

module bsh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_hash_value
);

   `BSH_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!rsp_valid && req_ready), "not idle after reset")
   `BSH_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_hash_value)), "stalled hash changed")
   `BSH_ASSERT(a_hash_nonzero, clock, reset, rsp_valid |-> (rsp_hash_value != 32'd0), "zero hash delivered")
   `BSH_ASSERT(a_no_early_rsp, clock, reset, $rose(rsp_valid) |-> !$past(req_valid && req_ready), "hash too soon after a word")

endmodule

bind byte_string_hash_unit bsh_checker u_bsh_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_hash_value (rsp_hash_value)
);

### sim/tb_byte_string_hash_unit.sv
// Testbench for the byte string hash unit: directed and random strings checked by a hash predictor
`timescale 1ns / 1ps

module tb_byte_string_hash_unit;

   localparam int CLK_PERIOD  = 20;
   localparam int TAIL_SETTLE = 12;
   localparam int DRAIN_LIMIT = 20000;

   logic                              clock             = 1'b0;
   logic                              reset             = 1'b1;
   logic                              req_valid         = 1'b0;
   logic                              req_ready;
   logic                              req_action        = bsh_pkg::ACTION_START;
   logic [bsh_pkg::LEN_PORT_BITS-1:0] req_string_length = '0;
   logic [7:0]                        req_byte_a        = '0;
   logic [7:0]                        req_byte_b        = '0;
   logic [7:0]                        req_byte_c        = '0;
   logic [7:0]                        req_byte_d        = '0;
   logic                              rsp_valid;
   logic                              rsp_ready         = 1'b0;
   logic [bsh_pkg::HASH_BITS-1:0]     rsp_hash_value;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count   = 0;

   logic [31:0] hash_expect_q[$];
   logic [31:0] hash_now;

   // Predictor copy of the running string state
   bit [31:0] mix_a     = '0;
   bit [31:0] mix_b     = '0;
   bit [23:0] len_left  = '0;
   bit [23:0] len_total = '0;
   bit        in_string = 1'b0;

   byte_string_hash_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_string_length (req_string_length),
      .req_byte_a        (req_byte_a),
      .req_byte_b        (req_byte_b),
      .req_byte_c        (req_byte_c),
      .req_byte_d        (req_byte_d),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hash_value    (rsp_hash_value)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   task automatic report_error(input string msg);
      error_count++;
      $display("ERROR at %0t: %s", $time, msg);
   endtask

   function automatic bit [31:0] finished_hash();
      bit [31:0] h;
      h = (mix_a * 32'd29311 + 32'd59) ^ (mix_b * 32'd7321 + 32'd120501);
      // fall back through the mix registers, then the length, to keep it nonzero
      if (h == 0) h = mix_a;
      if (h == 0) h = mix_b;
      if (h == 0) h = {8'd0, len_total} + 32'd11;
      return h;
   endfunction

   function automatic void absorb_word(input logic act, input logic [23:0] len,
                                       input logic [7:0] a, b, c, d);
      bit [31:0] s0, s1, s2, s3, left32, old_b;
      s0     = {{24{a[7]}}, a};
      s1     = {{24{b[7]}}, b};
      s2     = {{24{c[7]}}, c};
      s3     = {{24{d[7]}}, d};
      left32 = {8'd0, len_left};
      if (act == bsh_pkg::ACTION_START) begin
         mix_a     = '0;
         mix_b     = {8'd0, len};
         len_left  = len;
         len_total = len;
         in_string = (len != 0);
         if (len == 0) hash_expect_q.push_back(finished_hash());
      end else if (in_string) begin
         if (len_left > 4) begin
            old_b    = mix_b;
            mix_a    = (32'd509 * old_b + 32'd307 * s0) ^ (32'd1319 * s1);
            mix_b    = (32'd17 * left32 + 32'd5 + 32'd5309 * old_b)
                     ^ (32'd3313 * s2 + 32'd9337 * s3 + 32'd517);
            len_left = len_left - 24'd4;
         end else begin
            // tail chain: walk only as many bytes as remain
            mix_a = (mix_a * 32'd7703) ^ (32'd503 * s0);
            if (len_left > 1) begin
               mix_b = (mix_b * 32'd7717) ^ (32'd509 * s1);
               if (len_left > 2) begin
                  mix_a = (mix_a * 32'd9323) ^ (32'd11 + 32'd523 * s2);
                  if (len_left > 3) begin
                     mix_b = (mix_b * 32'd7727 + 32'd127) ^ (32'd313 + 32'd547 * s3);
                  end
               end
            end
            len_left  = '0;
            in_string = 1'b0;
            hash_expect_q.push_back(finished_hash());
         end
      end
   endfunction

   // Returns right after the accepting edge with valid still high
   task automatic send_item(input logic act, input logic [23:0] len,
                            input logic [7:0] a, b, c, d);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= act;
      req_string_length <= len;
      req_byte_a        <= a;
      req_byte_b        <= b;
      req_byte_c        <= c;
      req_byte_d        <= d;
      do @(posedge clock); while (!req_ready);
      absorb_word(act, len, a, b, c, d);
   endtask

   task automatic send_start(input logic [23:0] len);
      send_item(bsh_pkg::ACTION_START, len, 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom));
   endtask

   task automatic send_word(input logic [7:0] a, b, c, d);
      send_item(bsh_pkg::ACTION_WORD, 24'($urandom), a, b, c, d);
   endtask

   task automatic drain_expected();
      int guard;
      guard = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (hash_expect_q.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      if (hash_expect_q.size() != 0)
         report_error($sformatf("%0d expected hashes never returned", hash_expect_q.size()));
      repeat (TAIL_SETTLE) @(posedge clock);
   endtask

   // Check every accepted hash word against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (hash_expect_q.size() == 0) begin
            report_error($sformatf("unexpected hash_value %08h", rsp_hash_value));
         end else begin
            hash_now = hash_expect_q.pop_front();
            if (rsp_hash_value !== hash_now)
               report_error($sformatf("hash_value expected %08h got %08h",
                                      hash_now, rsp_hash_value));
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic test_zero_length();
      send_item(bsh_pkg::ACTION_START, 24'd0, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(bsh_pkg::ACTION_START, 24'd0, 8'hff, 8'hff, 8'hff, 8'hff);
   endtask

   task automatic test_tail_lengths();
      send_start(24'd1);
      send_word(8'h80, 8'h7f, 8'hff, 8'h00);
      send_start(24'd2);
      send_word(8'hff, 8'h80, 8'h7f, 8'h00);
      send_start(24'd3);
      send_word(8'h7f, 8'h00, 8'h80, 8'hff);
      send_start(24'd4);
      send_word(8'h80, 8'hff, 8'h00, 8'h7f);
   endtask

   task automatic test_round_then_tail();
      send_start(24'd5);
      send_word(8'hff, 8'hff, 8'hff, 8'hff);
      send_word(8'h80, 8'h80, 8'h80, 8'h80);
      send_start(24'd8);
      send_word(8'h7f, 8'h7f, 8'h7f, 8'h7f);
      send_word(8'h00, 8'h00, 8'h00, 8'h00);
   endtask

   task automatic test_idle_word_drop();
      send_word(8'h12, 8'h34, 8'h56, 8'h78);
   endtask

   task automatic test_abort_restart();
      send_start(24'hff_ffff);
      send_word(8'hff, 8'h80, 8'h7f, 8'h01);
      send_start(24'd6);
      send_word(8'h80, 8'h7f, 8'h00, 8'hff);
      send_word(8'h01, 8'hfe, 8'h55, 8'haa);
   endtask

   // Hold the sender until every hash is back, then resume
   task automatic test_drain_pause();
      send_start(24'd9);
      repeat (3) send_word(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      drain_expected();
      send_start(24'd3);
      send_word(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                      input int item_goal);
      int sent, pick, len, words;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      sent          = 0;
      while (sent < item_goal) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            // complete string, mostly short
            len   = ($urandom_range(99) < 85) ? $urandom_range(1, 24) : $urandom_range(25, 160);
            words = (len + 3) / 4;
         end else if (pick < 78) begin
            len   = 0;
            words = 0;
         end else if (pick < 88) begin
            // huge length, abandoned by the next start
            len   = $urandom & 24'hff_ffff;
            words = $urandom_range(0, 3);
         end else if (pick < 94) begin
            len   = $urandom_range(5, 40);
            words = $urandom_range(1, (len + 3) / 4 - 1);
         end else begin
            len   = -1;
            words = $urandom_range(1, 2);
         end
         if (len >= 0) begin
            send_start(24'(len));
            sent++;
         end
         for (int k = 0; k < words; k++) begin
            send_word(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            if (len >= 0) sent++;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_zero_length();
      test_tail_lengths();
      test_round_then_tail();
      test_idle_word_drop();
      test_abort_restart();
      send_idle_pct = 26;
      recv_idle_pct = 59;
      test_drain_pause();
      test_random_traffic(26, 59, 370);
      test_random_traffic(59, 26, 370);
      test_random_traffic(0, 0, 370);
      drain_expected();

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #(CLK_PERIOD * 1_000_000);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
